### design/dur_pkg.sv
package dur_pkg;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int ERR_W   = 4;
  localparam int MONTH_W = 31;
  localparam int SEC_W   = 63;
  localparam int NANO_W  = 30;

  // Fraction digits kept; later digits are dropped
  localparam int FRAC_DIGITS = 9;
  localparam int FCNT_W      = 4;

  // Scaled copies of the running digit value: x1, x12, x60, x3600, x86400
  localparam int NSCALE    = 5;
  localparam int SCL_IDX_W = 3;
  localparam int SCL_ONE   = 0;
  localparam int SCL_YEAR  = 1;
  localparam int SCL_MIN   = 2;
  localparam int SCL_HOUR  = 3;
  localparam int SCL_DAY   = 4;
  localparam int SCL_K_W   = 17;
  // Wide enough for scaled*10 + digit*k before the overflow test
  localparam int SCL_EXT_W = SEC_W + 4;

  // Characters
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
  localparam logic [CHAR_W-1:0] CH_H     = 8'h48;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
  localparam logic [CHAR_W-1:0] CH_Y     = 8'h59;

  typedef enum logic [3:0] {
    PH_START,
    PH_SIGN,
    PH_AFTER_P,
    PH_DATE,
    PH_DATE_NUM,
    PH_AFTER_T,
    PH_TIME,
    PH_TIME_NUM,
    PH_FRAC,
    PH_FAILED
  } phase_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK         = 4'd0,
    ERR_EMPTY      = 4'd1,
    ERR_NO_P       = 4'd2,
    ERR_AFTER_P    = 4'd3,
    ERR_NO_DIGIT   = 4'd4,
    ERR_NO_DESIG   = 4'd5,
    ERR_BAD_DESIG  = 4'd6,
    ERR_BAD_CHAR   = 4'd7,
    ERR_AFTER_T    = 4'd8,
    ERR_NO_S       = 4'd9,
    ERR_NO_TIME    = 4'd10,
    ERR_NO_COMP    = 4'd11,
    ERR_TRAILING   = 4'd12,
    ERR_OVERFLOW   = 4'd13
  } err_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              end_only;
    logic              last;
  } dur_item_t;

  typedef struct packed {
    err_t               error_code;
    logic               is_negative;
    logic [MONTH_W-1:0] month_total;
    logic [SEC_W-1:0]   second_total;
    logic [NANO_W-1:0]  nano_part;
  } dur_result_t;

  // Unit weight of each scaled copy
  function automatic logic [SCL_K_W-1:0] scale_k(input logic [SCL_IDX_W-1:0] idx);
    logic [SCL_K_W-1:0] k;
    unique case (idx)
      3'd0:    k = 17'd1;
      3'd1:    k = 17'd12;
      3'd2:    k = 17'd60;
      3'd3:    k = 17'd3600;
      3'd4:    k = 17'd86400;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Place value of a fraction digit in nanoseconds
  function automatic logic [NANO_W-1:0] pow10(input logic [FCNT_W-1:0] e);
    logic [NANO_W-1:0] p;
    unique case (e)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

### design/duration_string_parser.sv
// Channel   Direction  Handshake            Item
// in_       input      in_valid/in_ready    in_character, in_end_only, in_last
// out_      output     out_valid/out_ready  out_error_code, out_is_negative,
//                                           out_month_total, out_second_total,
//                                           out_nano_part
//
// One item per cycle unless an item that ends a string waits on a full result slot;
// the last item of a string passes the input register, then its result the result register.
// The parse step is one pass of decode plus one wide add and compare per
// accumulator, fed by registered digit copies pre-scaled by each unit.
// Reset is synchronous on rst_n low and returns the parser to string start.
// A stalled result holds only items that end a string; other items keep
// flowing past it.
module duration_string_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dur_pkg::CHAR_W-1:0]    in_character,
  input  logic                          in_end_only,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dur_pkg::ERR_W-1:0]     out_error_code,
  output logic                          out_is_negative,
  output logic [dur_pkg::MONTH_W-1:0]   out_month_total,
  output logic [dur_pkg::SEC_W-1:0]     out_second_total,
  output logic [dur_pkg::NANO_W-1:0]    out_nano_part
);

  logic                 item_valid;
  dur_pkg::dur_item_t   item;
  logic                 go;
  logic                 res_load;
  dur_pkg::dur_result_t res;
  logic                 out_free;

  // Held item advances unless it ends a string and the result slot is full
  assign go = item_valid && (!item.last || out_free);

  dur_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .in_end_only  (in_end_only),
    .in_last      (in_last),
    .go           (go),
    .item_valid   (item_valid),
    .item         (item)
  );

  dur_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .item     (item),
    .res_load (res_load),
    .res      (res)
  );

  dur_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (res_load),
    .res              (res),
    .free             (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_error_code   (out_error_code),
    .out_is_negative  (out_is_negative),
    .out_month_total  (out_month_total),
    .out_second_total (out_second_total),
    .out_nano_part    (out_nano_part)
  );

endmodule

### design/dur_in_stage.sv
module dur_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dur_pkg::CHAR_W-1:0]    in_character,
  input  logic                          in_end_only,
  input  logic                          in_last,
  input  logic                          go,
  output logic                          item_valid,
  output dur_pkg::dur_item_t            item
);

  logic               valid_r;
  dur_pkg::dur_item_t item_r;

  // Free when empty or when the held item moves on this cycle
  assign in_ready   = !valid_r || go;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (go) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.character <= in_character;
      item_r.end_only  <= in_end_only;
      item_r.last      <= in_last;
    end
  end

endmodule

### design/dur_core.sv
module dur_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  dur_pkg::dur_item_t    item,
  output logic                  res_load,
  output dur_pkg::dur_result_t  res
);

  localparam int MW = dur_pkg::MONTH_W;
  localparam int SW = dur_pkg::SEC_W;
  localparam int NW = dur_pkg::NANO_W;
  localparam int XW = dur_pkg::SCL_EXT_W;

  dur_pkg::phase_t phase_r, phase_nxt;
  dur_pkg::err_t   err_r, err_nxt;
  logic            sign_r, sign_nxt;
  logic            any_r, any_nxt;
  logic            time_r, time_nxt;
  logic [MW-1:0]   month_r, month_nxt;
  logic [SW-1:0]   sec_r, sec_nxt;
  logic [NW-1:0]   nano_r, nano_nxt;
  logic [dur_pkg::FCNT_W-1:0] fcnt_r, fcnt_nxt;

  // Running digit value times each unit weight, with sticky overflow flags
  logic [SW-1:0] scl_r   [dur_pkg::NSCALE];
  logic [SW-1:0] scl_nxt [dur_pkg::NSCALE];
  logic          sovf_r  [dur_pkg::NSCALE];
  logic          sovf_nxt[dur_pkg::NSCALE];

  logic [SW-1:0] scl_first[dur_pkg::NSCALE];
  logic [SW-1:0] scl_more [dur_pkg::NSCALE];
  logic          ovf_more [dur_pkg::NSCALE];

  logic [dur_pkg::CHAR_W-1:0] ch;
  logic                       is_digit;
  logic [3:0]                 dval;

  logic [dur_pkg::SCL_IDX_W-1:0] m_idx, s_idx;
  logic [SW:0]   msum, ssum;
  logic          mbad, sbad;
  logic [NW-1:0] nano_add;

  dur_pkg::err_t end_code;
  logic          nonzero;

  assign ch       = item.character;
  assign is_digit = (ch >= dur_pkg::CH_ZERO) && (ch <= dur_pkg::CH_NINE);
  assign dval     = ch[3:0];

  // Next scaled values: start of a run, or value*10 + digit*k
  always_comb begin
    logic [XW-1:0] ext;
    logic [XW-1:0] dk;
    logic [XW-1:0] sum;
    for (int i = 0; i < dur_pkg::NSCALE; i++) begin
      ext = XW'(scl_r[i]);
      dk  = XW'(dval) * XW'(dur_pkg::scale_k(dur_pkg::SCL_IDX_W'(i)));
      sum = (ext << 3) + (ext << 1) + dk;
      scl_first[i] = SW'(dk);
      scl_more[i]  = sum[SW-1:0];
      ovf_more[i]  = sovf_r[i] || (|sum[XW-1:SW]);
    end
  end

  // Month fold: Y adds twelve per unit, M adds one
  assign m_idx = (ch == dur_pkg::CH_Y) ? dur_pkg::SCL_IDX_W'(dur_pkg::SCL_YEAR)
                                      : dur_pkg::SCL_IDX_W'(dur_pkg::SCL_ONE);
  assign msum  = (SW+1)'(month_r) + (SW+1)'(scl_r[m_idx]);
  assign mbad  = sovf_r[m_idx] || (|msum[SW:MW]);

  // Second fold: D, H, M in time, S and the decimal point
  always_comb begin
    priority case (ch)
      dur_pkg::CH_D: s_idx = dur_pkg::SCL_IDX_W'(dur_pkg::SCL_DAY);
      dur_pkg::CH_H: s_idx = dur_pkg::SCL_IDX_W'(dur_pkg::SCL_HOUR);
      dur_pkg::CH_M: s_idx = dur_pkg::SCL_IDX_W'(dur_pkg::SCL_MIN);
      default:       s_idx = dur_pkg::SCL_IDX_W'(dur_pkg::SCL_ONE);
    endcase
  end
  assign ssum = (SW+1)'(sec_r) + (SW+1)'(scl_r[s_idx]);
  assign sbad = sovf_r[s_idx] || ssum[SW];

  // Fraction digit lands already padded to nanoseconds
  always_comb begin
    logic [NW+3:0] prod;
    prod     = (NW+4)'(dval) *
               (NW+4)'(dur_pkg::pow10(dur_pkg::FCNT_W'(8) - fcnt_r));
    nano_add = prod[NW-1:0];
  end

  // Parser step for one character
  always_comb begin
    phase_nxt = phase_r;
    err_nxt   = err_r;
    sign_nxt  = sign_r;
    any_nxt   = any_r;
    time_nxt  = time_r;
    month_nxt = month_r;
    sec_nxt   = sec_r;
    nano_nxt  = nano_r;
    fcnt_nxt  = fcnt_r;
    for (int i = 0; i < dur_pkg::NSCALE; i++) begin
      scl_nxt[i]  = scl_r[i];
      sovf_nxt[i] = sovf_r[i];
    end

    if (!item.end_only) begin
      unique case (phase_r)
        dur_pkg::PH_START: begin
          if (ch == dur_pkg::CH_MINUS) begin
            sign_nxt  = 1'b1;
            phase_nxt = dur_pkg::PH_SIGN;
          end else if (ch == dur_pkg::CH_P) begin
            phase_nxt = dur_pkg::PH_AFTER_P;
          end else begin
            phase_nxt = dur_pkg::PH_FAILED;
            err_nxt   = dur_pkg::ERR_NO_P;
          end
        end
        dur_pkg::PH_SIGN: begin
          if (ch == dur_pkg::CH_P) begin
            phase_nxt = dur_pkg::PH_AFTER_P;
          end else begin
            phase_nxt = dur_pkg::PH_FAILED;
            err_nxt   = dur_pkg::ERR_NO_P;
          end
        end
        dur_pkg::PH_AFTER_P, dur_pkg::PH_DATE: begin
          if (is_digit) begin
            for (int i = 0; i < dur_pkg::NSCALE; i++) begin
              scl_nxt[i]  = scl_first[i];
              sovf_nxt[i] = 1'b0;
            end
            phase_nxt = dur_pkg::PH_DATE_NUM;
          end else if (ch == dur_pkg::CH_T) begin
            phase_nxt = dur_pkg::PH_AFTER_T;
          end else begin
            phase_nxt = dur_pkg::PH_FAILED;
            err_nxt   = dur_pkg::ERR_BAD_CHAR;
          end
        end
        dur_pkg::PH_DATE_NUM: begin
          if (is_digit) begin
            for (int i = 0; i < dur_pkg::NSCALE; i++) begin
              scl_nxt[i]  = scl_more[i];
              sovf_nxt[i] = ovf_more[i];
            end
            if (ovf_more[dur_pkg::SCL_ONE]) begin
              phase_nxt = dur_pkg::PH_FAILED;
              err_nxt   = dur_pkg::ERR_OVERFLOW;
            end
          end else begin
            phase_nxt = dur_pkg::PH_DATE;
            any_nxt   = 1'b1;
            if (ch == dur_pkg::CH_Y || ch == dur_pkg::CH_M) begin
              if (mbad) begin
                phase_nxt = dur_pkg::PH_FAILED;
                err_nxt   = dur_pkg::ERR_OVERFLOW;
              end else begin
                month_nxt = msum[MW-1:0];
              end
            end else if (ch == dur_pkg::CH_D) begin
              if (sbad) begin
                phase_nxt = dur_pkg::PH_FAILED;
                err_nxt   = dur_pkg::ERR_OVERFLOW;
              end else begin
                sec_nxt = ssum[SW-1:0];
              end
            end else begin
              phase_nxt = dur_pkg::PH_FAILED;
              err_nxt   = dur_pkg::ERR_BAD_DESIG;
            end
          end
        end
        dur_pkg::PH_AFTER_T, dur_pkg::PH_TIME: begin
          if (is_digit) begin
            for (int i = 0; i < dur_pkg::NSCALE; i++) begin
              scl_nxt[i]  = scl_first[i];
              sovf_nxt[i] = 1'b0;
            end
            phase_nxt = dur_pkg::PH_TIME_NUM;
          end else begin
            phase_nxt = dur_pkg::PH_FAILED;
            err_nxt   = time_r ? dur_pkg::ERR_TRAILING : dur_pkg::ERR_NO_TIME;
          end
        end
        dur_pkg::PH_TIME_NUM: begin
          if (is_digit) begin
            for (int i = 0; i < dur_pkg::NSCALE; i++) begin
              scl_nxt[i]  = scl_more[i];
              sovf_nxt[i] = ovf_more[i];
            end
            if (ovf_more[dur_pkg::SCL_ONE]) begin
              phase_nxt = dur_pkg::PH_FAILED;
              err_nxt   = dur_pkg::ERR_OVERFLOW;
            end
          end else if (ch == dur_pkg::CH_H || ch == dur_pkg::CH_M ||
                       ch == dur_pkg::CH_S || ch == dur_pkg::CH_DOT) begin
            if (ch == dur_pkg::CH_DOT) begin
              phase_nxt = dur_pkg::PH_FRAC;
              fcnt_nxt  = '0;
            end else begin
              phase_nxt = dur_pkg::PH_TIME;
              time_nxt  = 1'b1;
              any_nxt   = 1'b1;
            end
            // seconds and the decimal point both clear the nanoseconds
            if (ch == dur_pkg::CH_S || ch == dur_pkg::CH_DOT) begin
              nano_nxt = '0;
            end
            if (sbad) begin
              phase_nxt = dur_pkg::PH_FAILED;
              err_nxt   = dur_pkg::ERR_OVERFLOW;
            end else begin
              sec_nxt = ssum[SW-1:0];
            end
          end else begin
            phase_nxt = dur_pkg::PH_FAILED;
            err_nxt   = dur_pkg::ERR_BAD_DESIG;
          end
        end
        dur_pkg::PH_FRAC: begin
          if (is_digit) begin
            if (fcnt_r < dur_pkg::FCNT_W'(dur_pkg::FRAC_DIGITS)) begin
              nano_nxt = nano_r + nano_add;
              fcnt_nxt = fcnt_r + 1'b1;
            end
          end else if (ch == dur_pkg::CH_S) begin
            phase_nxt = dur_pkg::PH_TIME;
            time_nxt  = 1'b1;
            any_nxt   = 1'b1;
          end else begin
            phase_nxt = dur_pkg::PH_FAILED;
            err_nxt   = dur_pkg::ERR_NO_S;
          end
        end
        dur_pkg::PH_FAILED: begin
          // first error stays; characters ignored until the end
        end
        default: begin
          phase_nxt = dur_pkg::PH_FAILED;
        end
      endcase
    end
  end

  // End-of-string code from the updated state
  always_comb begin
    unique case (phase_nxt)
      dur_pkg::PH_START:    end_code = dur_pkg::ERR_EMPTY;
      dur_pkg::PH_SIGN:     end_code = dur_pkg::ERR_NO_P;
      dur_pkg::PH_AFTER_P:  end_code = dur_pkg::ERR_AFTER_P;
      dur_pkg::PH_DATE:     end_code = any_nxt ? dur_pkg::ERR_OK : dur_pkg::ERR_NO_COMP;
      dur_pkg::PH_DATE_NUM: end_code = dur_pkg::ERR_NO_DESIG;
      dur_pkg::PH_AFTER_T:  end_code = dur_pkg::ERR_AFTER_T;
      dur_pkg::PH_TIME:     end_code = time_nxt ? dur_pkg::ERR_OK : dur_pkg::ERR_NO_TIME;
      dur_pkg::PH_TIME_NUM: end_code = dur_pkg::ERR_NO_DESIG;
      dur_pkg::PH_FRAC:     end_code = dur_pkg::ERR_NO_S;
      default:              end_code = err_nxt;
    endcase
  end

  // Result; errors and negative zero carry cleared fields
  assign nonzero  = (|month_nxt) || (|sec_nxt) || (|nano_nxt);
  assign res_load = go && item.last;

  always_comb begin
    res.error_code = end_code;
    if (end_code == dur_pkg::ERR_OK) begin
      res.is_negative  = sign_nxt && nonzero;
      res.month_total  = month_nxt;
      res.second_total = sec_nxt;
      res.nano_part    = nano_nxt;
    end else begin
      res.is_negative  = 1'b0;
      res.month_total  = '0;
      res.second_total = '0;
      res.nano_part    = '0;
    end
  end

  // Parser state; the last item of a string returns it to the start
  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      phase_r <= dur_pkg::PH_START;
      err_r   <= dur_pkg::ERR_OK;
      sign_r  <= 1'b0;
      any_r   <= 1'b0;
      time_r  <= 1'b0;
      month_r <= '0;
      sec_r   <= '0;
      nano_r  <= '0;
      fcnt_r  <= '0;
    end else if (go) begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      sign_r  <= sign_nxt;
      any_r   <= any_nxt;
      time_r  <= time_nxt;
      month_r <= month_nxt;
      sec_r   <= sec_nxt;
      nano_r  <= nano_nxt;
      fcnt_r  <= fcnt_nxt;
    end
  end

  // Scaled digit copies are loaded at the first digit of every run and extended by each later digit
  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < dur_pkg::NSCALE; i++) begin
        scl_r[i]  <= scl_nxt[i];
        sovf_r[i] <= sovf_nxt[i];
      end
    end
  end

endmodule

### design/dur_out_stage.sv
module dur_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  dur_pkg::dur_result_t            res,
  output logic                            free,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dur_pkg::ERR_W-1:0]       out_error_code,
  output logic                            out_is_negative,
  output logic [dur_pkg::MONTH_W-1:0]     out_month_total,
  output logic [dur_pkg::SEC_W-1:0]       out_second_total,
  output logic [dur_pkg::NANO_W-1:0]      out_nano_part
);

  logic                 valid_r;
  dur_pkg::dur_result_t res_r;

  // Slot opens when empty or when the held result is taken
  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_error_code   = res_r.error_code;
  assign out_is_negative  = res_r.is_negative;
  assign out_month_total  = res_r.month_total;
  assign out_second_total = res_r.second_total;
  assign out_nano_part    = res_r.nano_part;

endmodule

### design/dur_checker.sv
module dur_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [dur_pkg::ERR_W-1:0]     out_error_code,
  input  logic                          out_is_negative,
  input  logic [dur_pkg::MONTH_W-1:0]   out_month_total,
  input  logic [dur_pkg::SEC_W-1:0]     out_second_total,
  input  logic [dur_pkg::NANO_W-1:0]    out_nano_part
);

  // A stalled result holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_error_code) &&
      $stable(out_month_total) && $stable(out_second_total) &&
      $stable(out_nano_part) && $stable(out_is_negative))
    else $error("result changed while stalled");

  // Error results carry cleared fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != 4'd0 |-> !out_is_negative &&
      out_month_total == '0 && out_second_total == '0 && out_nano_part == '0)
    else $error("error result with nonzero fields");

  // No negative zero; nanoseconds stay below one second
  a_neg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_negative |-> out_month_total != '0 ||
      out_second_total != '0 || out_nano_part != '0)
    else $error("negative zero duration");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code != 4'd4 && out_error_code <= 4'd13 &&
      out_nano_part < 30'd1000000000)
    else $error("result code or nanoseconds out of range");

  // Nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind duration_string_parser dur_checker u_dur_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_error_code   (out_error_code),
  .out_is_negative  (out_is_negative),
  .out_month_total  (out_month_total),
  .out_second_total (out_second_total),
  .out_nano_part    (out_nano_part)
);

### test/tb_duration_string_parser.sv
`timescale 1ns / 1ps

module tb_duration_string_parser;
  import dur_pkg::*;

  localparam int          RUN_LIMIT   = 400000;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [63:0] SEC_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MONTH_LIMIT = 64'h0000_0000_7FFF_FFFF;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CHAR_W-1:0]   in_character;
  logic                in_end_only;
  logic                in_last;
  logic                out_valid;
  logic                out_ready;
  logic [ERR_W-1:0]    out_error_code;
  logic                out_is_negative;
  logic [MONTH_W-1:0]  out_month_total;
  logic [SEC_W-1:0]    out_second_total;
  logic [NANO_W-1:0]   out_nano_part;

  duration_string_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_character     (in_character),
    .in_end_only      (in_end_only),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_error_code   (out_error_code),
    .out_is_negative  (out_is_negative),
    .out_month_total  (out_month_total),
    .out_second_total (out_second_total),
    .out_nano_part    (out_nano_part)
  );

  // Directed string table
  typedef struct {
    string       text;
    bit          end_term;   // close the string with a no-character item
    int          gap_at;     // no-character item inserted before this index
    bit          typed;      // use the hand-written result below
    dur_result_t want;
  } row_t;

  row_t              rows[$];
  logic [CHAR_W-1:0] str_buf[$];
  dur_result_t       due_results[$];
  string             char_pool = "-PTYMDHS.0123456789";

  int mismatch_count = 0;
  int items_sent     = 0;
  int cycle_count    = 0;
  bit quiet          = 0;
  bit hold_req       = 0;

  // Parser state mirror
  phase_t      parse_phase;
  bit          minus_seen;
  logic [63:0] run_value;
  logic [63:0] month_sum;
  logic [63:0] second_sum;
  logic [31:0] nano_sum;
  int          frac_count;
  bit          saw_component;
  bit          saw_time;
  err_t        first_error;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("duration_string_parser verification failed");
      $finish;
    end
  end

  task automatic note_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
  endtask

  // ---------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------
  task automatic clear_parser();
    parse_phase   = PH_START;
    minus_seen    = 0;
    run_value     = '0;
    month_sum     = '0;
    second_sum    = '0;
    nano_sum      = '0;
    frac_count    = 0;
    saw_component = 0;
    saw_time      = 0;
    first_error   = ERR_OK;
  endtask

  task automatic latch_error(err_t e);
    if (first_error == ERR_OK) first_error = e;
    parse_phase = PH_FAILED;
  endtask

  function automatic bit fits(logic [63:0] acc, logic [63:0] v, logic [63:0] k,
                              logic [63:0] lim);
    return !(acc > lim || v > (lim - acc) / k);
  endfunction

  task automatic fold_months(logic [63:0] k);
    if (fits(month_sum, run_value, k, MONTH_LIMIT)) month_sum += run_value * k;
    else latch_error(ERR_OVERFLOW);
  endtask

  task automatic fold_seconds(logic [63:0] k);
    if (fits(second_sum, run_value, k, SEC_LIMIT)) second_sum += run_value * k;
    else latch_error(ERR_OVERFLOW);
  endtask

  task automatic append_digit(logic [63:0] d);
    if (run_value > (SEC_LIMIT - d) / 10) latch_error(ERR_OVERFLOW);
    else run_value = run_value * 10 + d;
  endtask

  task automatic parse_char(logic [CHAR_W-1:0] c);
    bit          is_dig;
    logic [63:0] d;
    int          n;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d      = {56'd0, c - CH_ZERO};
    case (parse_phase)
      PH_START: begin
        if (c == CH_MINUS) begin
          minus_seen  = 1;
          parse_phase = PH_SIGN;
        end else if (c == CH_P) parse_phase = PH_AFTER_P;
        else latch_error(ERR_NO_P);
      end
      PH_SIGN: begin
        if (c == CH_P) parse_phase = PH_AFTER_P;
        else latch_error(ERR_NO_P);
      end
      PH_AFTER_P, PH_DATE: begin
        if (is_dig) begin
          run_value   = d;
          parse_phase = PH_DATE_NUM;
        end else if (c == CH_T) parse_phase = PH_AFTER_T;
        else latch_error(ERR_BAD_CHAR);
      end
      PH_DATE_NUM: begin
        if (is_dig) append_digit(d);
        else begin
          parse_phase   = PH_DATE;
          saw_component = 1;
          if (c == CH_Y) fold_months(12);
          else if (c == CH_M) fold_months(1);
          else if (c == CH_D) fold_seconds(86400);
          else latch_error(ERR_BAD_DESIG);
        end
      end
      PH_AFTER_T, PH_TIME: begin
        if (is_dig) begin
          run_value   = d;
          parse_phase = PH_TIME_NUM;
        end else latch_error(saw_time ? ERR_TRAILING : ERR_NO_TIME);
      end
      PH_TIME_NUM: begin
        if (is_dig) append_digit(d);
        else if (c == CH_H || c == CH_M || c == CH_S) begin
          parse_phase   = PH_TIME;
          saw_time      = 1;
          saw_component = 1;
          if (c == CH_H) fold_seconds(3600);
          else if (c == CH_M) fold_seconds(60);
          else begin
            nano_sum = '0;
            fold_seconds(1);
          end
        end else if (c == CH_DOT) begin
          parse_phase = PH_FRAC;
          nano_sum    = '0;
          frac_count  = 0;
          fold_seconds(1);
        end else latch_error(ERR_BAD_DESIG);
      end
      PH_FRAC: begin
        if (is_dig) begin
          // digits past the kept count are dropped
          if (frac_count < FRAC_DIGITS) begin
            nano_sum = nano_sum * 10 + d[31:0];
            frac_count++;
          end
        end else if (c == CH_S) begin
          for (n = frac_count; n < FRAC_DIGITS; n++) nano_sum = nano_sum * 10;
          parse_phase   = PH_TIME;
          saw_time      = 1;
          saw_component = 1;
        end else latch_error(ERR_NO_S);
      end
      default: ;
    endcase
  endtask

  task automatic close_string(output dur_result_t r);
    err_t code;
    case (parse_phase)
      PH_START:                 code = ERR_EMPTY;
      PH_SIGN:                  code = ERR_NO_P;
      PH_AFTER_P:               code = ERR_AFTER_P;
      PH_DATE:                  code = saw_component ? ERR_OK : ERR_NO_COMP;
      PH_DATE_NUM, PH_TIME_NUM: code = ERR_NO_DESIG;
      PH_AFTER_T:               code = ERR_AFTER_T;
      PH_TIME:                  code = saw_time ? ERR_OK : ERR_NO_TIME;
      PH_FRAC:                  code = ERR_NO_S;
      default:                  code = first_error;
    endcase
    r = '0;
    r.error_code = code;
    if (code == ERR_OK) begin
      // minus on an all-zero duration is dropped
      r.is_negative  = minus_seen && (month_sum != 0 || second_sum != 0 || nano_sum != 0);
      r.month_total  = month_sum[MONTH_W-1:0];
      r.second_total = second_sum[SEC_W-1:0];
      r.nano_part    = nano_sum[NANO_W-1:0];
    end
    clear_parser();
  endtask

  // ---------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------
  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(1)) return char_pool[$urandom_range(char_pool.len() - 1)];
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic put(string s);
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endtask

  task automatic push_item(logic [CHAR_W-1:0] c, logic eo, logic lst, bit typed,
                           dur_result_t want);
    dur_result_t pred;
    while (!quiet && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= c;
    in_end_only  <= eo;
    in_last      <= lst;
    do @(posedge clk); while (!in_ready);
    if (!eo) parse_char(c);
    if (lst) begin
      close_string(pred);
      due_results.push_back(typed ? want : pred);
    end
    items_sent++;
  endtask

  task automatic send_string(bit end_term, int gap_at, bit typed, dur_result_t want);
    int n;
    n = str_buf.size();
    if (n == 0) end_term = 1;
    for (int i = 0; i < n; i++) begin
      if (i == gap_at) push_item(pick_char(), 1'b1, 1'b0, 1'b0, want);
      push_item(str_buf[i], 1'b0, !end_term && i == n - 1, typed, want);
    end
    if (end_term) push_item(pick_char(), 1'b1, 1'b1, typed, want);
  endtask

  // Digit run: mostly short, some long enough to overflow
  task automatic add_number();
    int sel;
    int len;
    sel = $urandom_range(99);
    if (sel < 3) put($urandom_range(1) ? "9223372036854775807" : "9223372036854775808");
    else begin
      if (sel < 70) len = $urandom_range(3, 1);
      else if (sel < 90) len = $urandom_range(10, 4);
      else len = $urandom_range(20, 11);
      repeat (len) str_buf.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
    end
  endtask

  task automatic build_random(output bit end_term, output int gap_at);
    int    kind;
    int    date_cnt;
    int    time_cnt;
    int    cut;
    string dsg;
    dsg = "YMD";
    str_buf.delete();
    kind = $urandom_range(99);
    if (kind < 6) begin
      // plain noise
      repeat ($urandom_range(8)) str_buf.push_back(pick_char());
    end else begin
      date_cnt = 0;
      time_cnt = 0;
      if ($urandom_range(3) == 0) put("-");
      put("P");
      for (int j = 0; j < 3; j++) begin
        if ($urandom_range(1)) begin
          add_number();
          str_buf.push_back(dsg[j]);
          date_cnt++;
        end
      end
      // repeated or out-of-order date designator
      if ($urandom_range(9) == 0) begin
        add_number();
        str_buf.push_back(dsg[$urandom_range(2)]);
        date_cnt++;
      end
      if (date_cnt == 0 || $urandom_range(9) < 6) begin
        put("T");
        if ($urandom_range(1)) begin
          add_number();
          put("H");
          time_cnt++;
        end
        if ($urandom_range(1)) begin
          add_number();
          put("M");
          time_cnt++;
        end
        if (time_cnt == 0 || $urandom_range(1)) begin
          add_number();
          if ($urandom_range(1)) begin
            put(".");
            repeat ($urandom_range(12)) str_buf.push_back(CH_ZERO + CHAR_W'($urandom_range(9)));
          end
          put("S");
        end
      end
      // broken variants
      if (kind < 14) begin
        str_buf[$urandom_range(str_buf.size() - 1)] = pick_char();
      end else if (kind < 22) begin
        cut = $urandom_range(str_buf.size() - 1);
        while (str_buf.size() > cut) void'(str_buf.pop_back());
      end else if (kind < 27) begin
        repeat ($urandom_range(3, 1)) str_buf.push_back(pick_char());
      end
    end
    end_term = ($urandom_range(9) == 0);
    gap_at   = ($urandom_range(9) == 0) ? $urandom_range(str_buf.size()) : -1;
  endtask

  task automatic add_row(string text, bit end_term, int gap_at, bit typed, err_t err,
                         bit neg, logic [MONTH_W-1:0] mon, logic [SEC_W-1:0] sec,
                         logic [NANO_W-1:0] ns);
    row_t r;
    r.text              = text;
    r.end_term          = end_term;
    r.gap_at            = gap_at;
    r.typed             = typed;
    r.want.error_code   = err;
    r.want.is_negative  = neg;
    r.want.month_total  = mon;
    r.want.second_total = sec;
    r.want.nano_part    = ns;
    rows.push_back(r);
  endtask

  // Stimulus
  initial begin
    dur_result_t none;
    bit          end_term;
    int          gap_at;
    int          rand_start;
    bit          hold_done;
    none         = '0;
    hold_done    = 0;
    in_valid     = 1'b0;
    in_character = '0;
    in_end_only  = 1'b0;
    in_last      = 1'b0;
    rst_n        = 1'b0;
    clear_parser();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // error codes, extremes and special cases
    add_row("",      1, -1, 1, ERR_EMPTY,     0, 0, 0, 0);
    add_row("X",     0, -1, 1, ERR_NO_P,      0, 0, 0, 0);
    add_row("-",     0, -1, 1, ERR_NO_P,      0, 0, 0, 0);
    add_row("P",     0, -1, 1, ERR_AFTER_P,   0, 0, 0, 0);
    add_row("P1",    0, -1, 1, ERR_NO_DESIG,  0, 0, 0, 0);
    add_row("P1X",   0, -1, 1, ERR_BAD_DESIG, 0, 0, 0, 0);
    add_row("PX",    0, -1, 1, ERR_BAD_CHAR,  0, 0, 0, 0);
    add_row("PT",    0, -1, 1, ERR_AFTER_T,   0, 0, 0, 0);
    add_row("PTX",   0, -1, 1, ERR_NO_TIME,   0, 0, 0, 0);
    add_row("PT1HX", 0, -1, 1, ERR_TRAILING,  0, 0, 0, 0);
    add_row("PT1.5", 0, -1, 1, ERR_NO_S,      0, 0, 0, 0);
    add_row("PX1Y",  0, -1, 1, ERR_BAD_CHAR,  0, 0, 0, 0);
    add_row("P99999999999999999999D", 0, -1, 1, ERR_OVERFLOW, 0, 0, 0, 0);
    add_row("P178956971Y", 0, -1, 1, ERR_OVERFLOW, 0, 0, 0, 0);
    add_row("P178956970Y7M", 0, -1, 1, ERR_OK, 0, 31'h7FFF_FFFF, 0, 0);
    add_row("PT9223372036854775807S", 0, -1, 1, ERR_OK, 0, 0,
            63'h7FFF_FFFF_FFFF_FFFF, 0);
    add_row("PT9223372036854775807S1S", 0, -1, 1, ERR_OVERFLOW, 0, 0, 0, 0);
    add_row("-P0D",            0, -1, 1, ERR_OK, 0, 0, 0, 0);
    add_row("-PT0.000000000S", 0, -1, 1, ERR_OK, 0, 0, 0, 0);
    add_row("PT0.999999999S",  0, -1, 1, ERR_OK, 0, 0, 0, 999999999);
    add_row("PT0.1234567891234S", 0, -1, 1, ERR_OK, 0, 0, 0, 123456789);
    add_row("PT7.S",    0, -1, 1, ERR_OK, 0, 0, 7, 0);
    add_row("PT1.5S2S", 0, -1, 1, ERR_OK, 0, 0, 3, 0);
    // checked against the predictor
    add_row("-P1Y2M3DT4H5M6.789S", 0, -1, 0, ERR_OK, 0, 0, 0, 0);
    add_row("P2D1Y3Y", 0, -1, 0, ERR_OK, 0, 0, 0, 0);
    add_row("P5D",     0,  1, 0, ERR_OK, 0, 0, 0, 0);
    add_row("PT30M",   1, -1, 0, ERR_OK, 0, 0, 0, 0);
    add_row("-PT0.5S", 1,  3, 0, ERR_OK, 0, 0, 0, 0);

    foreach (rows[i]) begin
      str_buf.delete();
      put(rows[i].text);
      send_string(rows[i].end_term, rows[i].gap_at, rows[i].typed, rows[i].want);
    end

    // Random strings: idle-free stretch, then one long receiver hold-off
    rand_start = items_sent;
    while (items_sent < rand_start + 1800) begin
      quiet = (items_sent >= rand_start + 500) && (items_sent < rand_start + 850);
      if (!hold_done && items_sent >= rand_start + 1200) begin
        hold_req  = 1;
        hold_done = 1;
      end
      build_random(end_term, gap_at);
      send_string(end_term, gap_at, 0, none);
    end
    quiet = 0;
    in_valid <= 1'b0;

    // drain
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("duration_string_parser verification clean");
    end else begin
      $display("duration_string_parser verification failed");
    end
    $finish;
  end

  // Result side ready: random stalls, idle-free stretch, long hold-off
  initial begin
    int hold_left;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 1'b0;
        for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(posedge clk);
      end
      out_ready <= quiet || ($urandom_range(99) >= 24);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin : check_results
    dur_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        note_mismatch("unexpected result, error_code", out_error_code, 0);
      end else begin
        want = due_results.pop_front();
        if (out_error_code !== want.error_code)
          note_mismatch("error_code", out_error_code, want.error_code);
        if (out_is_negative !== want.is_negative)
          note_mismatch("is_negative", out_is_negative, want.is_negative);
        if (out_month_total !== want.month_total)
          note_mismatch("month_total", out_month_total, want.month_total);
        if (out_second_total !== want.second_total)
          note_mismatch("second_total", out_second_total, want.second_total);
        if (out_nano_part !== want.nano_part)
          note_mismatch("nano_part", out_nano_part, want.nano_part);
      end
    end
  end

endmodule
